// File: rtl/bist_pkg.sv
// Shared types and constants for the bounded integer set table.
// No dependencies; used by bist_core and bounded_integer_set_table.
package bist_pkg;

  // Default table depth and register reset value
  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CountW        = 5;
  localparam logic [CountW-1:0] CapReset = 5'd16;

  // Bit positions within the kind field
  localparam int unsigned KindLookupBit = 0;
  localparam int unsigned KindClearBit  = 1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  // Input word
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_t;

  // Result word
  typedef struct packed {
    logic [2:0]        status;
    logic [CountW-1:0] element_count;
  } out_t;

endpackage

// File: rtl/bist_core.sv
// Set engine: entry memory, fill count and the scan sequencer.
// Depends on bist_pkg.
module bist_core #(
  parameter int unsigned MAX_ENTRIES = bist_pkg::MaxEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  bist_pkg::in_t               in_data_i,
  output logic                        busy_o,
  input  logic [bist_pkg::CountW-1:0] cap_i,
  input  logic                        res_free_i,
  output logic                        res_valid_o,
  output bist_pkg::out_t              res_data_o
);

  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned CW    = bist_pkg::CountW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          chk_q;
  logic                   hit_q;
  logic [1:0]             kind_q;
  logic [31:0]            value_q;
  logic [31:0]            rd_data_q;
  logic [31:0]            mem_q [Depth];
  logic [CW-1:0]          rd_idx;
  logic [CW+AddrW-1:0]    rd_ext;
  logic [CW+AddrW-1:0]    wr_ext;
  logic [AddrW-1:0]       rd_addr;
  logic [AddrW-1:0]       wr_addr;
  logic                   accept;
  logic                   full;
  logic                   do_write;
  logic [CW-1:0]          chk_next;
  bist_pkg::status_e      status;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign chk_next = chk_q + 1'b1;

  // Read address: entry 0 on accept, next entry while scanning
  assign rd_idx  = (state_q == S_SCAN) ? chk_next : '0;
  assign rd_ext  = {{AddrW{1'b0}}, rd_idx};
  assign rd_addr = rd_ext[AddrW-1:0];
  assign wr_ext  = {{AddrW{1'b0}}, count_q};
  assign wr_addr = wr_ext[AddrW-1:0];

  // Full when the count reaches the limit or the table depth
  assign full = (count_q >= cap_i) || (int'(count_q) >= int'(MAX_ENTRIES));

  // Work out the status of the held word
  always_comb begin
    do_write = 1'b0;
    if (kind_q[bist_pkg::KindClearBit]) begin
      status = bist_pkg::ST_CLEARED;
    end else if (kind_q[bist_pkg::KindLookupBit]) begin
      status = hit_q ? bist_pkg::ST_FOUND : bist_pkg::ST_NOTFOUND;
    end else if (hit_q) begin
      status = bist_pkg::ST_PRESENT;
    end else if (full) begin
      status = bist_pkg::ST_FULL;
    end else begin
      status   = bist_pkg::ST_ADDED;
      do_write = 1'b1;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
    if ((state_q == S_DECIDE) && res_free_i && do_write) begin
      mem_q[wr_addr] <= value_q;
    end
  end

  // Hold the operand words
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_data_i.kind;
      value_q <= in_data_i.value;
    end
  end

  // Sequencer: scan filled entries, then commit the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      chk_q       <= '0;
      hit_q       <= 1'b0;
      res_valid_o <= 1'b0;
      res_data_o  <= '0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            chk_q <= '0;
            hit_q <= 1'b0;
            if (in_data_i.kind[bist_pkg::KindClearBit] || (count_q == '0)) begin
              state_q <= S_DECIDE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_data_q == value_q) begin
            hit_q   <= 1'b1;
            state_q <= S_DECIDE;
          end else if (chk_next == count_q) begin
            state_q <= S_DECIDE;
          end else begin
            chk_q <= chk_next;
          end
        end
        S_DECIDE: begin
          if (res_free_i) begin
            res_valid_o       <= 1'b1;
            res_data_o.status <= status;
            if (kind_q[bist_pkg::KindClearBit]) begin
              count_q                  <= '0;
              res_data_o.element_count <= '0;
            end else if (do_write) begin
              count_q                  <= count_q + 1'b1;
              res_data_o.element_count <= count_q + 1'b1;
            end else begin
              res_data_o.element_count <= count_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bounded_integer_set_table.sv
// Top level of the bounded integer set table: capacity register, output register.
// Depends on bist_pkg and bist_core.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes one word per
// operation: insert, lookup or clear. Each word yields exactly one result word on
// the output channel (out_valid_o, out_stall_i, out_data_o): a status code and
// the element count after the operation.
// The capacity limit is written through cfg_valid_i/cfg_ready_o/cfg_data_i; the
// user must write it while the block is idle, which the block does not enforce;
// cfg_ready_o is always high.
// A clear, or any operation on an empty set, goes from acceptance straight to the
// decide state; otherwise the stored entries are scanned first (up to the element
// count, fewer on an early match). The scan reads one entry a cycle from a memory
// with one write port and one registered read port; one word is in flight at a
// time, so a new word is taken only once the result of the last is committed.
// Reset empties the set and sets the capacity limit to 16; table contents are
// not cleared. When the receiver stalls, the result stays in the output register
// and a further finished result waits inside the engine; the input stalls.
module bounded_integer_set_table #(
  parameter int unsigned MAX_ENTRIES = bist_pkg::MaxEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bist_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bist_pkg::out_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bist_pkg::CountW-1:0] cfg_data_i
);

  logic [bist_pkg::CountW-1:0] cap_q;
  logic                        out_valid_q;
  bist_pkg::out_t              out_data_q;
  logic                        res_free;
  logic                        res_valid;
  bist_pkg::out_t              res_data;
  logic                        busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign res_free    = !out_valid_q || !out_stall_i;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bist_pkg::CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Output register: load a new word, drop one once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_data;
    end
  end

  bist_core #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .busy_o      (busy),
    .cap_i       (cap_q),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

endmodule
